FILE: src/postfix_stack_evaluator_assert.svh
// Assertion macros for the postfix stack evaluator.
// Depends on nothing; the files that check themselves include it.
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define PSE_ASSERT(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// A condition that must be followed by another one in the next cycle.
`define PSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSE_ASSERT(label, clk, rst_n, expr, msg)
`define PSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: src/pse_pkg.sv
// Shared types and constants of the postfix stack evaluator.
// Used by the stack, the ALU and the top level; depends on nothing.
`default_nettype none
package pse_pkg;

  localparam int unsigned SYM_W  = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ST_W   = 3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [ST_W-1:0] ST_ZERODIV   = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  localparam logic [SYM_W-1:0] CH_0   = 8'h30;
  localparam logic [SYM_W-1:0] CH_9   = 8'h39;
  localparam logic [SYM_W-1:0] CH_ADD = 8'h2b;
  localparam logic [SYM_W-1:0] CH_SUB = 8'h2d;
  localparam logic [SYM_W-1:0] CH_MUL = 8'h2a;
  localparam logic [SYM_W-1:0] CH_DIV = 8'h2f;
  localparam logic [SYM_W-1:0] CH_REM = 8'h25;
  localparam logic [SYM_W-1:0] CH_POW = 8'h5e;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_REM,
    ALU_POW,
    ALU_ZERO
  } alu_op_e;

  typedef enum logic [2:0] {
    A_IDLE,
    A_DIV,
    A_FIX,
    A_POW_ACC,
    A_POW_SQ,
    A_DONE
  } alu_state_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_FIN
  } seq_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic zero_div;
  } alu_rsp_t;

  // Maps an operator character onto the ALU operation; anything unknown yields zero.
  function automatic alu_op_e decode_op(input logic [SYM_W-1:0] sym);
    alu_op_e op;
    case (sym)
      CH_ADD:  op = ALU_ADD;
      CH_SUB:  op = ALU_SUB;
      CH_MUL:  op = ALU_MUL;
      CH_DIV:  op = ALU_DIV;
      CH_REM:  op = ALU_REM;
      CH_POW:  op = ALU_POW;
      default: op = ALU_ZERO;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

FILE: src/pse_stack.sv
// Operand stack memory: one write port and one registered read port.
// Depends on pse_pkg for the word width.
`default_nettype none
module pse_stack
  import pse_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

FILE: src/pse_alu.sv
// Shared arithmetic unit: add, subtract, one 32x32 multiplier reused for
// multiply and power, and a radix-2 restoring divider. Depends on pse_pkg.
`default_nettype none
module pse_alu
  import pse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire alu_req_t          req_i,
  input  wire logic [DATA_W-1:0] a_i,
  input  wire logic [DATA_W-1:0] b_i,
  output alu_rsp_t               rsp_o,
  output logic      [DATA_W-1:0] result_o
);

  alu_state_e state_q, state_d;

  logic [DATA_W-1:0] res_q;     // result, and the accumulator during power
  logic              zdiv_q;
  logic [DATA_W-1:0] quo_q;     // dividend shifting into quotient
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] mb_q;      // divisor magnitude
  logic [DATA_W-1:0] sq_q;      // running square of the base
  logic [DATA_W-1:0] exp_q;
  logic [4:0]        cnt_q;
  logic              neg_q;
  logic              is_div_q;

  logic [DATA_W-1:0] mul_x, mul_y;
  logic [2*DATA_W-1:0] prod_full;
  logic [DATA_W-1:0] prod;
  logic [DATA_W:0]   rem_sh, diff;
  logic [DATA_W-1:0] abs_a, abs_b;

  assign abs_a = a_i[DATA_W-1] ? (DATA_W'(0) - a_i) : a_i;
  assign abs_b = b_i[DATA_W-1] ? (DATA_W'(0) - b_i) : b_i;

  // Multiplier operand selection.
  always_comb begin
    mul_x = sq_q;
    mul_y = sq_q;
    if (state_q == A_IDLE) begin
      mul_x = a_i;
      mul_y = b_i;
    end else if (state_q == A_POW_ACC && exp_q[0]) begin
      mul_x = res_q;
      mul_y = sq_q;
    end
  end

  assign prod_full = mul_x * mul_y;
  assign prod      = prod_full[DATA_W-1:0];

  assign rem_sh = {rem_q, quo_q[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, mb_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            ALU_DIV, ALU_REM: state_d = (b_i == '0) ? A_DONE : A_DIV;
            ALU_POW:          state_d = b_i[DATA_W-1] ? A_DONE : A_POW_ACC;
            default:          state_d = A_DONE;
          endcase
        end
      end
      A_DIV:     state_d = (cnt_q == 5'd31) ? A_FIX : A_DIV;
      A_FIX:     state_d = A_DONE;
      A_POW_ACC: begin
        if (exp_q == '0) begin
          state_d = A_DONE;
        end else if (exp_q[0]) begin
          state_d = A_POW_SQ;
        end
      end
      A_POW_SQ:  state_d = A_POW_ACC;
      A_DONE:    state_d = A_IDLE;
      default:   state_d = A_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    rsp_o.done     = (state_q == A_DONE);
    rsp_o.zero_div = zdiv_q;
    result_o       = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          zdiv_q   <= 1'b0;
          quo_q    <= abs_a;
          mb_q     <= abs_b;
          rem_q    <= '0;
          cnt_q    <= '0;
          is_div_q <= (req_i.op == ALU_DIV);
          neg_q    <= (req_i.op == ALU_DIV) ? (a_i[DATA_W-1] ^ b_i[DATA_W-1])
                                            : a_i[DATA_W-1];
          sq_q     <= a_i;
          exp_q    <= b_i;
          case (req_i.op)
            ALU_ADD: res_q <= a_i + b_i;
            ALU_SUB: res_q <= a_i - b_i;
            ALU_MUL: res_q <= prod;
            ALU_DIV, ALU_REM: begin
              res_q  <= '0;
              zdiv_q <= (b_i == '0);
            end
            ALU_POW: begin
              if (b_i[DATA_W-1]) begin
                // Negative exponent: only a base of one or minus one survives.
                if (a_i == DATA_W'(1)) begin
                  res_q <= DATA_W'(1);
                end else if (a_i == '1) begin
                  res_q <= b_i[0] ? '1 : DATA_W'(1);
                end else begin
                  res_q <= '0;
                end
                zdiv_q <= (a_i == '0);
              end else begin
                res_q <= DATA_W'(1);
              end
            end
            default: res_q <= '0;
          endcase
        end
      end
      A_DIV: begin
        cnt_q <= cnt_q + 5'd1;
        if (!diff[DATA_W]) begin
          rem_q <= diff[DATA_W-1:0];
          quo_q <= {quo_q[DATA_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[DATA_W-1:0];
          quo_q <= {quo_q[DATA_W-2:0], 1'b0};
        end
      end
      A_FIX: begin
        if (is_div_q) begin
          res_q <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
        end else begin
          res_q <= neg_q ? (DATA_W'(0) - rem_q) : rem_q;
        end
      end
      A_POW_ACC: begin
        if (exp_q != '0) begin
          if (exp_q[0]) begin
            res_q <= prod;
          end else begin
            sq_q  <= prod;
            exp_q <= exp_q >> 1;
          end
        end
      end
      A_POW_SQ: begin
        sq_q  <= prod;
        exp_q <= exp_q >> 1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator: sequencer, top-of-stack register,
// output register. Depends on pse_pkg, pse_stack, pse_alu and the assert header.
//
//  channel  | dir | tdata bits (low first)              | tlast
//  s_axis   | in  | [7:0] symbol                        | last
//  m_axis   | out | [31:0] value, [34:32] status, zeros | -
//
// A digit is pushed as it is accepted. An operator passes the execute and wait
// states and the ALU: add, subtract, multiply and unknown characters go straight
// to done, divide and modulo run the divider (one quotient bit per cycle), power
// steps through square and accumulate (one multiplier shared by both). A final
// character then loads the output register, which waits there while m_axis stalls.
// Reset clears the sequencer, the count and the error; no clearing pass runs.
`default_nettype none
`include "postfix_stack_evaluator_assert.svh"
module postfix_stack_evaluator
  import pse_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [39:0] m_axis_tdata_o    // [31:0] value, [34:32] status
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  seq_state_e state_q, state_d;

  logic [CW-1:0]     count_q, count_d;
  logic [ST_W-1:0]   err_q, err_d;
  logic [DATA_W-1:0] top_q, top_d;
  alu_op_e           op_q;
  logic              last_q;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q;
  logic [ST_W-1:0]   out_status_q;

  logic              accept, is_digit, out_load, enough;
  logic [CW-1:0]     cnt_m2;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data, rd_data, alu_res, digit_val;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_digit  = s_axis_tdata_i inside {[CH_0:CH_9]};
  assign enough    = (count_q >= CW'(2));
  assign cnt_m2    = count_q - CW'(2);
  assign digit_val = {{(DATA_W-SYM_W){1'b0}}, s_axis_tdata_i - CH_0};
  assign out_load  = (state_q == S_FIN) && (!out_valid_q || m_axis_tready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_digit || !enough) begin
            state_d = s_axis_tlast_i ? S_FIN : S_IDLE;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC:  state_d = S_WAIT;
      S_WAIT:  if (alu_rsp.done) state_d = last_q ? S_FIN : S_IDLE;
      S_FIN:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE);
    alu_req.start   = (state_q == S_EXEC);
    alu_req.op      = op_q;
    rd_en           = accept && !is_digit && enough;
    wr_en           = 1'b0;
    wr_addr         = count_q[AW-1:0];
    wr_data         = digit_val;
    if (accept && is_digit && (count_q < CW'(STACK_DEPTH))) begin
      wr_en = 1'b1;
    end else if (state_q == S_WAIT && alu_rsp.done) begin
      wr_en   = 1'b1;
      wr_addr = cnt_m2[AW-1:0];
      wr_data = alu_res;
    end
  end

  // Stack pointer, top of stack and sticky error.
  always_comb begin
    count_d = count_q;
    err_d   = err_q;
    top_d   = top_q;
    if (accept) begin
      if (is_digit) begin
        if (count_q < CW'(STACK_DEPTH)) begin
          count_d = count_q + CW'(1);
          top_d   = digit_val;
        end else if (err_q == ST_OK) begin
          err_d = ST_OVERFLOW;
        end
      end else if (!enough && err_q == ST_OK) begin
        err_d = ST_UNDERFLOW;
      end
    end
    if (state_q == S_WAIT && alu_rsp.done) begin
      count_d = count_q - CW'(1);
      top_d   = alu_res;
      if (alu_rsp.zero_div && err_q == ST_OK) begin
        err_d = ST_ZERODIV;
      end
    end
    if (out_load) begin
      count_d = '0;
      err_d   = ST_OK;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (accept) begin
      op_q   <= decode_op(s_axis_tdata_i);
      last_q <= s_axis_tlast_i;
    end
    if (out_load) begin
      if (err_q != ST_OK) begin
        out_value_q  <= '0;
        out_status_q <= err_q;
      end else if (count_q == '0) begin
        out_value_q  <= '0;
        out_status_q <= ST_EMPTY;
      end else begin
        out_value_q  <= top_q;
        out_status_q <= ST_OK;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_status_q, out_value_q};

  pse_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(cnt_m2[AW-1:0]),
    .rd_data_o(rd_data)
  );

  pse_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .a_i     (rd_data),
    .b_i     (top_q),
    .rsp_o   (alu_rsp),
    .result_o(alu_res)
  );

  `PSE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(STACK_DEPTH), "stack count overrun")
  `PSE_ASSERT(a_done_in_wait, clk_i, rst_ni, !alu_rsp.done || state_q == S_WAIT, "ALU done outside wait")
  `PSE_ASSERT_NEXT(a_clear_on_load, clk_i, rst_ni, out_load, count_q == '0 && err_q == ST_OK && m_axis_tvalid_o, "expression state not cleared")

endmodule
`default_nettype wire
